FILE: src/boma_pkg.sv
`timescale 1ns / 1ps

package boma_pkg;

    // Fixed field widths
    localparam int PRICE_BITS     = 32;
    localparam int FRACTION_BITS  = 8;
    localparam int AVG_BITS       = 40;
    localparam int PAIRS_BITS     = 13;
    localparam int LOOKBACK_BITS  = 13;
    localparam int LOOKBACK_RESET = 10;

    // Register file: one 32-bit register, byte address 4 * index
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic REG_LOOKBACK = 1'b0;

    typedef struct packed {
        logic [PRICE_BITS-1:0] bar_high;
        logic [PRICE_BITS-1:0] bar_low;
    } bar_t;

    typedef struct packed {
        logic [AVG_BITS-1:0]   average_overlap;
        logic [PAIRS_BITS-1:0] pairs_used;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV,
        ST_DONE
    } boma_state_t;

endpackage

FILE: src/bar_overlap_moving_average_unit.sv
`timescale 1ns / 1ps

// Moving average of the overlap between consecutive price bars.
// Bar channel (bar_valid / bar_stall / bar): one transaction per bar, high and
// low in ticks. Result channel (res_valid / res_stall / res): one transaction
// per bar with the mean overlap (8 fraction bits, truncated) and the number of
// overlaps in the window. The first bar after reset gives zero and zero.
// A bar that forms a pair goes from acceptance through the update, division
// and done states to its result; the first bar goes straight to done. The
// restoring divider produces one quotient bit per cycle. bar_stall is low
// only while the block is idle, so a bar is taken only after the previous one
// has left the done state; its result sits in the output register, so the
// next bar is taken while res_stall holds the previous result.
// Overlaps live in a MAX_LOOKBACK-deep ring memory with a registered read; the
// oldest entry is read at acceptance and the new one written in the next cycle.
// Reset sets lookback to 10 and empties the history; the ring needs no
// clearing pass because entries are read only after they were written.
// Writing lookback over APB (byte address 0) empties the history again but
// keeps the prior bar. Configure only while no bar is in flight.
module bar_overlap_moving_average_unit
    import boma_pkg::*;
#(
    parameter int MAX_LOOKBACK = 4096
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // bar channel
    input  logic                     bar_valid,
    output logic                     bar_stall,
    input  bar_t                     bar,
    // result channel
    output logic                     res_valid,
    input  logic                     res_stall,
    output res_t                     res,
    // configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int PTR_W  = (MAX_LOOKBACK > 1) ? $clog2(MAX_LOOKBACK) : 1;
    localparam int CNT_W  = $clog2(MAX_LOOKBACK + 1);
    localparam int AW     = CNT_W + 1;
    localparam int SUM_W  = PRICE_BITS + CNT_W;
    localparam int DIVD_W = SUM_W + FRACTION_BITS;
    localparam int STEP_W = $clog2(DIVD_W + 1);

    // Control state
    boma_state_t              state_reg, state_next;
    logic [LOOKBACK_BITS-1:0] lookback_reg, lookback_next;
    logic                     have_prior_reg, have_prior_next;
    logic [PTR_W-1:0]         ptr_reg, ptr_next;
    logic [CNT_W-1:0]         pairs_reg, pairs_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic                     full_reg, full_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     res_valid_reg, res_valid_next;

    // Datapath
    logic [PRICE_BITS-1:0]    prev_high_reg, prev_high_next;
    logic [PRICE_BITS-1:0]    prev_low_reg, prev_low_next;
    logic [PRICE_BITS-1:0]    ov_reg, ov_next;
    logic [DIVD_W-1:0]        quo_reg, quo_next;
    logic [CNT_W-1:0]         rem_reg, rem_next;
    res_t                     res_reg, res_next;
    logic [PRICE_BITS-1:0]    rd_data_reg;

    // Ring memory
    logic [PRICE_BITS-1:0]    ring_mem [MAX_LOOKBACK];
    logic                     ring_re;
    logic                     ring_we;
    logic [PTR_W-1:0]         rd_addr;

    logic                     bar_accept;
    logic                     cfg_we;
    logic                     res_free;
    logic [CNT_W-1:0]         win;
    logic [AW-1:0]            slot_ext;
    logic [AW-1:0]            old_ext;
    logic [PRICE_BITS-1:0]    ov_top;
    logic [PRICE_BITS-1:0]    ov_bot;
    logic [PRICE_BITS-1:0]    ov_calc;
    logic [AW-1:0]            rem_sh;
    logic [AW-1:0]            div_ext;

    assign bar_accept = bar_valid && !bar_stall;
    assign cfg_we     = psel && penable && pwrite && pready && (paddr[2] == REG_LOOKBACK);
    assign res_free   = !res_valid_reg || !res_stall;

    // Clamp lookback to 1..MAX_LOOKBACK
    always_comb
    begin
        if (lookback_reg == '0)
        begin
            win = CNT_W'(1);
        end
        else if (int'(lookback_reg) > MAX_LOOKBACK)
        begin
            win = CNT_W'(MAX_LOOKBACK);
        end
        else
        begin
            win = CNT_W'(lookback_reg);
        end
    end

    // Locate the entry that leaves the window
    assign slot_ext = AW'(ptr_reg);
    assign old_ext  = (slot_ext >= AW'(win)) ? (slot_ext - AW'(win))
                                             : (slot_ext + AW'(MAX_LOOKBACK) - AW'(win));
    assign rd_addr  = old_ext[PTR_W-1:0];

    // Overlap of the incoming bar with the prior bar
    assign ov_top  = (bar.bar_high < prev_high_reg) ? bar.bar_high : prev_high_reg;
    assign ov_bot  = (bar.bar_low > prev_low_reg) ? bar.bar_low : prev_low_reg;
    assign ov_calc = (ov_top > ov_bot) ? (ov_top - ov_bot) : '0;

    // One restoring division step
    assign rem_sh  = {rem_reg, quo_reg[DIVD_W-1]};
    assign div_ext = AW'(pairs_reg);

    // Next state and datapath
    always_comb
    begin
        state_next      = state_reg;
        lookback_next   = lookback_reg;
        have_prior_next = have_prior_reg;
        ptr_next        = ptr_reg;
        pairs_next      = pairs_reg;
        sum_next        = sum_reg;
        full_next       = full_reg;
        step_next       = step_reg;
        res_valid_next  = res_valid_reg;
        prev_high_next  = prev_high_reg;
        prev_low_next   = prev_low_reg;
        ov_next         = ov_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        res_next        = res_reg;
        ring_re         = 1'b0;
        ring_we         = 1'b0;

        // drop a delivered result
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (bar_accept)
                begin
                    prev_high_next  = bar.bar_high;
                    prev_low_next   = bar.bar_low;
                    have_prior_next = 1'b1;
                    ov_next         = ov_calc;
                    full_next       = (pairs_reg >= win);
                    ring_re         = (pairs_reg >= win);
                    if (have_prior_reg)
                    begin
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        quo_next   = '0;
                        state_next = ST_DONE;
                    end
                end
            end

            ST_UPDATE:
            begin
                // retire the oldest overlap, add the new one, advance the ring
                ring_we  = 1'b1;
                sum_next = sum_reg - (full_reg ? SUM_W'(rd_data_reg) : '0) + SUM_W'(ov_reg);
                if (full_reg)
                begin
                    pairs_next = win;
                end
                else
                begin
                    pairs_next = pairs_reg + CNT_W'(1);
                end
                if (slot_ext == AW'(MAX_LOOKBACK - 1))
                begin
                    ptr_next = '0;
                end
                else
                begin
                    ptr_next = ptr_reg + PTR_W'(1);
                end
                quo_next   = {sum_next, {FRACTION_BITS{1'b0}}};
                rem_next   = '0;
                step_next  = '0;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                if (rem_sh >= div_ext)
                begin
                    rem_next = CNT_W'(rem_sh - div_ext);
                    quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = CNT_W'(rem_sh);
                    quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIVD_W - 1))
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // hold until the output register is free
                if (res_free)
                begin
                    res_next.average_overlap = AVG_BITS'(quo_reg);
                    res_next.pairs_used      = PAIRS_BITS'(pairs_reg);
                    res_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // lookback write empties the history, keeps the prior bar
        if (cfg_we)
        begin
            lookback_next = pwdata[LOOKBACK_BITS-1:0];
            ptr_next      = '0;
            pairs_next    = '0;
            sum_next      = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            lookback_reg   <= LOOKBACK_BITS'(LOOKBACK_RESET);
            have_prior_reg <= 1'b0;
            ptr_reg        <= '0;
            pairs_reg      <= '0;
            sum_reg        <= '0;
            full_reg       <= 1'b0;
            step_reg       <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            lookback_reg   <= lookback_next;
            have_prior_reg <= have_prior_next;
            ptr_reg        <= ptr_next;
            pairs_reg      <= pairs_next;
            sum_reg        <= sum_next;
            full_reg       <= full_next;
            step_reg       <= step_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prev_high_reg <= prev_high_next;
        prev_low_reg  <= prev_low_next;
        ov_reg        <= ov_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        res_reg       <= res_next;
    end

    // Overlap ring: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ptr_reg] <= ov_reg;
        end
        if (ring_re)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    // Ports
    assign bar_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_LOOKBACK) ? APB_DATA_BITS'(lookback_reg) : '0;

    // The window never holds more overlaps than the clamped lookback
    a_pairs_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        pairs_reg <= win)
        else $error("pair count exceeds window");

    // The divisor is nonzero and the partial remainder stays below it
    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (pairs_reg != '0) && (rem_reg < pairs_reg))
        else $error("division remainder out of range");

    // A bar with no prior bar goes straight to the result
    a_first_bar: assert property (@(posedge clk) disable iff (!rst_n)
        (bar_accept && !have_prior_reg) |=> (state_reg == ST_DONE) && (quo_reg == '0))
        else $error("first bar did not yield zero");

    // A new result is only launched out of the done state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !$past(res_valid_reg && res_stall)) |->
            $past(state_reg == ST_DONE))
        else $error("result launched outside done state");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench
    import boma_pkg::*;
();

    localparam int  WINDOW_DEPTH = 4096;
    localparam int  CYCLE_LIMIT  = 500_000;
    localparam int  IDLE_PCT     = 12;
    localparam int  LONG_HOLD    = 3000;
    localparam logic [PRICE_BITS-1:0] PRICE_MAX = '1;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     bar_valid = 1'b0;
    logic                     bar_stall;
    bar_t                     bar_item = '0;
    logic                     res_valid;
    logic                     res_stall = 1'b0;
    res_t                     res;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    // Bars waiting to be offered, and the averages they are predicted to give
    bar_t bars_pending[$];
    res_t averages_due[$];

    int unsigned bars_sent = 0;
    int unsigned averages_seen = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_left = 0;
    res_t        due_average;

    // Predictor state: mirrored register, prior bar and overlap window
    logic [LOOKBACK_BITS-1:0] lookback_reg = LOOKBACK_BITS'(LOOKBACK_RESET);
    logic [PRICE_BITS-1:0]    prev_high = '0;
    logic [PRICE_BITS-1:0]    prev_low = '0;
    logic                     have_prior = 1'b0;
    logic [PRICE_BITS-1:0]    overlap_hist [WINDOW_DEPTH];
    logic [11:0]              hist_ptr = '0;
    logic [12:0]              pairs_seen = '0;
    logic [43:0]              window_sum = '0;

    // Random walk for well-formed bars
    longint unsigned price_center = 64'd1_000_000;
    bar_t            last_bar = '0;

    bar_overlap_moving_average_unit #(
        .MAX_LOOKBACK(WINDOW_DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .bar_valid(bar_valid),
        .bar_stall(bar_stall),
        .bar      (bar_item),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res      (res),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // Fold one bar into the window and return the average it yields
    function automatic res_t advance_window(bar_t b);
        logic [PRICE_BITS-1:0] top;
        logic [PRICE_BITS-1:0] bot;
        logic [PRICE_BITS-1:0] ovl;
        logic [12:0]           win;
        logic [11:0]           oldest;
        logic [51:0]           scaled;
        logic [51:0]           quotient;
        res_t                  r;
        r = '0;
        if (have_prior)
        begin
            top = (b.bar_high < prev_high) ? b.bar_high : prev_high;
            bot = (b.bar_low > prev_low) ? b.bar_low : prev_low;
            ovl = (top > bot) ? top - bot : '0;
            win = (lookback_reg == 0) ? 13'd1 :
                  (lookback_reg > WINDOW_DEPTH) ? 13'(WINDOW_DEPTH) : lookback_reg;
            if (pairs_seen >= win)
            begin
                // drop the overlap that falls out of the window
                oldest = hist_ptr - win[11:0];
                window_sum = window_sum - 44'(overlap_hist[oldest]);
                pairs_seen = win;
            end
            else
            begin
                pairs_seen = pairs_seen + 13'd1;
            end
            overlap_hist[hist_ptr] = ovl;
            window_sum = window_sum + 44'(ovl);
            hist_ptr = hist_ptr + 12'd1;
            scaled = {window_sum, {FRACTION_BITS{1'b0}}};
            quotient = scaled / {39'd0, pairs_seen};
            r.average_overlap = quotient[AVG_BITS-1:0];
            r.pairs_used = pairs_seen;
        end
        prev_high = b.bar_high;
        prev_low = b.bar_low;
        have_prior = 1'b1;
        return r;
    endfunction

    // Draw one bar: mostly a random walk, plus wide, inverted and extreme noise and repeats
    function automatic bar_t make_bar();
        int unsigned     kind;
        longint unsigned step;
        longint unsigned up;
        longint unsigned down;
        bar_t            b;
        kind = $urandom_range(99);
        if (kind < 3)
            price_center = 64'($urandom);
        step = longint'($urandom) & ((64'd1 << $urandom_range(20)) - 1);
        if ($urandom_range(1) == 1)
            price_center = (price_center + step > PRICE_MAX) ? 64'(PRICE_MAX)
                                                             : price_center + step;
        else
            price_center = (price_center > step) ? price_center - step : 64'd0;
        up = longint'($urandom) & ((64'd1 << $urandom_range(31)) - 1);
        down = longint'($urandom) & ((64'd1 << $urandom_range(31)) - 1);
        b.bar_high = (price_center + up > PRICE_MAX) ? PRICE_MAX : 32'(price_center + up);
        b.bar_low = (price_center > down) ? 32'(price_center - down) : '0;
        if (kind >= 70 && kind < 80)
        begin
            b.bar_high = $urandom;
            b.bar_low = $urandom;
        end
        else if (kind >= 80 && kind < 88)
        begin
            b = '{bar_high: b.bar_low, bar_low: b.bar_high};
        end
        else if (kind >= 88 && kind < 95)
        begin
            b.bar_high = ($urandom_range(1) == 1) ? PRICE_MAX : '0;
            b.bar_low = ($urandom_range(2) == 0) ? PRICE_MAX :
                        ($urandom_range(1) == 0) ? '0 : 32'($urandom);
        end
        else if (kind >= 95)
        begin
            b = last_bar;
        end
        last_bar = b;
        return b;
    endfunction

    task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
    endtask

    // Wait until no bar is queued or in flight and every average has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (bars_pending.size() != 0 || averages_due.size() != 0 || bar_valid);
    endtask

    // Write lookback over APB, read it back and clear the predicted history
    task automatic write_lookback(logic [APB_DATA_BITS-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_BITS'(4 * int'(REG_LOOKBACK));
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        lookback_reg = value[LOOKBACK_BITS-1:0];
        hist_ptr = '0;
        pairs_seen = '0;
        window_sum = '0;
        @(posedge clk);
        psel <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata !== APB_DATA_BITS'(lookback_reg))
            note_mismatch("lookback readback", 64'(lookback_reg), 64'(prdata));
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(logic [APB_DATA_BITS-1:0] lookback, int unsigned count);
        wait_drained();
        repeat (4) @(negedge clk);
        write_lookback(lookback);
        @(negedge clk);
        repeat (count) bars_pending.push_back(make_bar());
    endtask

    task automatic queue_bar(logic [PRICE_BITS-1:0] high, logic [PRICE_BITS-1:0] low);
        bars_pending.push_back('{bar_high: high, bar_low: low});
    endtask

    // Offer queued bars; hold each one until it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bar_valid <= 1'b0;
            bar_item <= '0;
        end
        else
        begin
            if (bar_valid && !bar_stall)
            begin
                averages_due.push_back(advance_window(bar_item));
                void'(bars_pending.pop_front());
                bars_sent++;
            end
            if (!bar_valid || !bar_stall)
            begin
                if (bars_pending.size() != 0 &&
                    ((bars_sent >= 300 && bars_sent < 500) || $urandom_range(99) >= IDLE_PCT))
                begin
                    bar_valid <= 1'b1;
                    bar_item <= bars_pending[0];
                end
                else
                begin
                    bar_valid <= 1'b0;
                end
            end
        end
    end

    // Check each average against the oldest prediction; stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (averages_due.size() == 0)
                begin
                    note_mismatch("result with none expected", '0, 64'(res));
                end
                else
                begin
                    due_average = averages_due.pop_front();
                    if (res.average_overlap !== due_average.average_overlap)
                        note_mismatch("average_overlap", 64'(due_average.average_overlap),
                                      64'(res.average_overlap));
                    if (res.pairs_used !== due_average.pairs_used)
                        note_mismatch("pairs_used", 64'(due_average.pairs_used),
                                      64'(res.pairs_used));
                end
                averages_seen++;
                // hold off long enough for the bar channel to back up
                if (averages_seen == 200 || averages_seen == 650)
                    hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= !(averages_seen >= 320 && averages_seen < 520) &&
                             ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("bar_overlap_moving_average_unit test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // first bar, full-range overlaps, flat and touching bars, inverted bars,
        // and enough pairs to fill the reset window of ten
        queue_bar(PRICE_MAX, '0);
        queue_bar(PRICE_MAX, '0);
        queue_bar(PRICE_MAX, '0);
        queue_bar('0, '0);
        queue_bar('0, '0);
        queue_bar(PRICE_MAX, PRICE_MAX);
        queue_bar(PRICE_MAX, PRICE_MAX - 1);
        queue_bar(32'd100, 32'd200);
        queue_bar(32'd300, 32'd50);
        queue_bar(32'd250, 32'd100);
        queue_bar(32'd400, 32'd250);
        queue_bar(32'd1000, 32'd0);
        repeat (4) queue_bar(32'd1000, 32'd0);
        queue_bar(32'h8000_0000, 32'h7FFF_FFFF);
        queue_bar(32'hAAAA_AAAA, 32'h5555_5555);
        queue_bar(32'h5555_5555, 32'hAAAA_AAAA);

        run_phase(32'd1, 100);
        run_phase(32'd0, 70);
        run_phase(32'd8191, 90);
        run_phase(32'd2, 100);
        run_phase(32'($urandom_range(3, 200)), 200);
        // widest window, still filling
        run_phase(32'(WINDOW_DEPTH), 200);
        run_phase(32'($urandom_range(201, 4095)), 120);

        wait_drained();
        repeat (60) @(posedge clk);
        if (mismatch_count == 0)
            $display("bar_overlap_moving_average_unit test passed");
        else
            $display("bar_overlap_moving_average_unit test failed");
        $finish;
    end

endmodule
